// File: sv/sh4alu_pkg.sv
// ----------------------------------------------------------------------------
// sh4alu_pkg
// Shared constants, operation classes and item types of the SH-4 integer
// execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package sh4alu_pkg;

   // queue depths
   localparam int unsigned QUEUE_DEPTH  = 2;
   localparam int unsigned RESULT_DEPTH = 2;

   // item modes
   localparam logic [1:0] MODE_EXEC   = 2'd0;
   localparam logic [1:0] MODE_LDREG  = 2'd1;
   localparam logic [1:0] MODE_LDMACH = 2'd2;
   localparam logic [1:0] MODE_LDMACL = 2'd3;

   // operation classes produced by the decoder
   localparam int unsigned OP_W = 6;
   localparam logic [OP_W-1:0] OP_UNKNOWN = 6'd0;
   localparam logic [OP_W-1:0] OP_CLRT    = 6'd1;
   localparam logic [OP_W-1:0] OP_SETT    = 6'd2;
   localparam logic [OP_W-1:0] OP_CLRS    = 6'd3;
   localparam logic [OP_W-1:0] OP_SETS    = 6'd4;
   localparam logic [OP_W-1:0] OP_DIV0U   = 6'd5;
   localparam logic [OP_W-1:0] OP_MOVT    = 6'd6;
   localparam logic [OP_W-1:0] OP_MULL    = 6'd7;
   localparam logic [OP_W-1:0] OP_DIV0S   = 6'd8;
   localparam logic [OP_W-1:0] OP_TST     = 6'd9;
   localparam logic [OP_W-1:0] OP_CMPSTR  = 6'd10;
   localparam logic [OP_W-1:0] OP_XTRCT   = 6'd11;
   localparam logic [OP_W-1:0] OP_MULUW   = 6'd12;
   localparam logic [OP_W-1:0] OP_MULSW   = 6'd13;
   localparam logic [OP_W-1:0] OP_CMPEQ   = 6'd14;
   localparam logic [OP_W-1:0] OP_CMPHS   = 6'd15;
   localparam logic [OP_W-1:0] OP_CMPGE   = 6'd16;
   localparam logic [OP_W-1:0] OP_DIV1    = 6'd17;
   localparam logic [OP_W-1:0] OP_DMULU   = 6'd18;
   localparam logic [OP_W-1:0] OP_CMPHI   = 6'd19;
   localparam logic [OP_W-1:0] OP_CMPGT   = 6'd20;
   localparam logic [OP_W-1:0] OP_SUBC    = 6'd21;
   localparam logic [OP_W-1:0] OP_SUBV    = 6'd22;
   localparam logic [OP_W-1:0] OP_DMULS   = 6'd23;
   localparam logic [OP_W-1:0] OP_ADDC    = 6'd24;
   localparam logic [OP_W-1:0] OP_ADDV    = 6'd25;
   localparam logic [OP_W-1:0] OP_SHLL    = 6'd26;
   localparam logic [OP_W-1:0] OP_SHLR    = 6'd27;
   localparam logic [OP_W-1:0] OP_ROTL    = 6'd28;
   localparam logic [OP_W-1:0] OP_ROTR    = 6'd29;
   localparam logic [OP_W-1:0] OP_DT      = 6'd30;
   localparam logic [OP_W-1:0] OP_CMPPZ   = 6'd31;
   localparam logic [OP_W-1:0] OP_CMPPL   = 6'd32;
   localparam logic [OP_W-1:0] OP_SHAR    = 6'd33;
   localparam logic [OP_W-1:0] OP_ROTCL   = 6'd34;
   localparam logic [OP_W-1:0] OP_ROTCR   = 6'd35;
   localparam logic [OP_W-1:0] OP_SHAD    = 6'd36;
   localparam logic [OP_W-1:0] OP_SHLD    = 6'd37;
   localparam logic [OP_W-1:0] OP_NOT     = 6'd38;
   localparam logic [OP_W-1:0] OP_SWAPB   = 6'd39;
   localparam logic [OP_W-1:0] OP_SWAPW   = 6'd40;
   localparam logic [OP_W-1:0] OP_NEGC    = 6'd41;
   localparam logic [OP_W-1:0] OP_NEG     = 6'd42;
   localparam logic [OP_W-1:0] OP_EXTUB   = 6'd43;
   localparam logic [OP_W-1:0] OP_EXTUW   = 6'd44;
   localparam logic [OP_W-1:0] OP_EXTSB   = 6'd45;
   localparam logic [OP_W-1:0] OP_EXTSW   = 6'd46;
   localparam logic [OP_W-1:0] OP_CMPIM   = 6'd47;
   localparam logic [OP_W-1:0] OP_TSTIM   = 6'd48;
   localparam logic [OP_W-1:0] OP_LDREG   = 6'd49;
   localparam logic [OP_W-1:0] OP_LDMACH  = 6'd50;
   localparam logic [OP_W-1:0] OP_LDMACL  = 6'd51;

   // decoded item handed from front to back
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [3:0]      rn_idx;   // first read address, also write address
      logic [3:0]      rb_idx;   // second read address (Rm, or R0 for immediates)
      logic [7:0]      imm;
      logic [31:0]     value;
   } dec_item_type;

   // result item
   typedef struct packed {
      logic        reg_written;
      logic [3:0]  reg_number;
      logic [31:0] reg_result;
      logic        t_out;
      logic        q_out;
      logic        m_out;
      logic        s_out;
      logic [31:0] mac_high_out;
      logic [31:0] mac_low_out;
      logic        unknown_op;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: sv/sh4alu_fifo.sv
// ----------------------------------------------------------------------------
// sh4alu_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sh4alu_fifo #(
   parameter int unsigned DEPTH = 2,
   parameter int unsigned WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: sv/sh4alu_decode.sv
// ----------------------------------------------------------------------------
// sh4alu_decode
// Front end: classifies an incoming item into an operation class and
// register addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module sh4alu_decode (
   input  wire logic [1:0]          mode,
   input  wire logic [15:0]         instruction,
   input  wire logic [3:0]          load_index,
   input  wire logic [31:0]         load_value,
   output sh4alu_pkg::dec_item_type item
);

   logic [3:0]                  n_fld, m_fld, lo;
   logic [7:0]                  lb;
   logic [sh4alu_pkg::OP_W-1:0] op;

   assign n_fld = instruction[11:8];
   assign m_fld = instruction[7:4];
   assign lo    = instruction[3:0];
   assign lb    = instruction[7:0];

   // opcode classification
   always_comb begin
      op = sh4alu_pkg::OP_UNKNOWN;
      unique case (instruction[15:12])
         4'h0: begin
            if (instruction == 16'h0008)                    op = sh4alu_pkg::OP_CLRT;
            else if (instruction == 16'h0018)               op = sh4alu_pkg::OP_SETT;
            else if (instruction == 16'h0048)               op = sh4alu_pkg::OP_CLRS;
            else if (instruction == 16'h0058)               op = sh4alu_pkg::OP_SETS;
            else if (instruction == 16'h0019)               op = sh4alu_pkg::OP_DIV0U;
            else if ((instruction & 16'hF0FF) == 16'h0029)  op = sh4alu_pkg::OP_MOVT;
            else if (lo == 4'h7)                            op = sh4alu_pkg::OP_MULL;
         end
         4'h2: begin
            unique case (lo)
               4'h7:    op = sh4alu_pkg::OP_DIV0S;
               4'h8:    op = sh4alu_pkg::OP_TST;
               4'hC:    op = sh4alu_pkg::OP_CMPSTR;
               4'hD:    op = sh4alu_pkg::OP_XTRCT;
               4'hE:    op = sh4alu_pkg::OP_MULUW;
               4'hF:    op = sh4alu_pkg::OP_MULSW;
               default: op = sh4alu_pkg::OP_UNKNOWN;
            endcase
         end
         4'h3: begin
            unique case (lo)
               4'h0:    op = sh4alu_pkg::OP_CMPEQ;
               4'h2:    op = sh4alu_pkg::OP_CMPHS;
               4'h3:    op = sh4alu_pkg::OP_CMPGE;
               4'h4:    op = sh4alu_pkg::OP_DIV1;
               4'h5:    op = sh4alu_pkg::OP_DMULU;
               4'h6:    op = sh4alu_pkg::OP_CMPHI;
               4'h7:    op = sh4alu_pkg::OP_CMPGT;
               4'hA:    op = sh4alu_pkg::OP_SUBC;
               4'hB:    op = sh4alu_pkg::OP_SUBV;
               4'hD:    op = sh4alu_pkg::OP_DMULS;
               4'hE:    op = sh4alu_pkg::OP_ADDC;
               4'hF:    op = sh4alu_pkg::OP_ADDV;
               default: op = sh4alu_pkg::OP_UNKNOWN;
            endcase
         end
         4'h4: begin
            if (lo == 4'hC)      op = sh4alu_pkg::OP_SHAD;
            else if (lo == 4'hD) op = sh4alu_pkg::OP_SHLD;
            else begin
               unique case (lb)
                  8'h00, 8'h20: op = sh4alu_pkg::OP_SHLL;
                  8'h01:        op = sh4alu_pkg::OP_SHLR;
                  8'h04:        op = sh4alu_pkg::OP_ROTL;
                  8'h05:        op = sh4alu_pkg::OP_ROTR;
                  8'h10:        op = sh4alu_pkg::OP_DT;
                  8'h11:        op = sh4alu_pkg::OP_CMPPZ;
                  8'h15:        op = sh4alu_pkg::OP_CMPPL;
                  8'h21:        op = sh4alu_pkg::OP_SHAR;
                  8'h24:        op = sh4alu_pkg::OP_ROTCL;
                  8'h25:        op = sh4alu_pkg::OP_ROTCR;
                  default:      op = sh4alu_pkg::OP_UNKNOWN;
               endcase
            end
         end
         4'h6: begin
            unique case (lo)
               4'h7:    op = sh4alu_pkg::OP_NOT;
               4'h8:    op = sh4alu_pkg::OP_SWAPB;
               4'h9:    op = sh4alu_pkg::OP_SWAPW;
               4'hA:    op = sh4alu_pkg::OP_NEGC;
               4'hB:    op = sh4alu_pkg::OP_NEG;
               4'hC:    op = sh4alu_pkg::OP_EXTUB;
               4'hD:    op = sh4alu_pkg::OP_EXTUW;
               4'hE:    op = sh4alu_pkg::OP_EXTSB;
               4'hF:    op = sh4alu_pkg::OP_EXTSW;
               default: op = sh4alu_pkg::OP_UNKNOWN;
            endcase
         end
         4'h8:    if (n_fld == 4'h8) op = sh4alu_pkg::OP_CMPIM;
         4'hC:    if (n_fld == 4'h8) op = sh4alu_pkg::OP_TSTIM;
         default: op = sh4alu_pkg::OP_UNKNOWN;
      endcase
   end

   // build the decoded item; load modes override the class
   always_comb begin
      item.op     = op;
      item.rn_idx = n_fld;
      item.rb_idx = m_fld;
      item.imm    = lb;
      item.value  = load_value;
      unique case (mode)
         sh4alu_pkg::MODE_LDREG: begin
            item.op     = sh4alu_pkg::OP_LDREG;
            item.rn_idx = load_index;
         end
         sh4alu_pkg::MODE_LDMACH: item.op = sh4alu_pkg::OP_LDMACH;
         sh4alu_pkg::MODE_LDMACL: item.op = sh4alu_pkg::OP_LDMACL;
         default: begin
            // immediate forms read R0 on the second port
            if (op == sh4alu_pkg::OP_CMPIM || op == sh4alu_pkg::OP_TSTIM) begin
               item.rb_idx = 4'h0;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/sh4alu_exec.sv
// ----------------------------------------------------------------------------
// sh4alu_exec
// Back end: register file read stage and execute stage with status bits,
// multiplier and accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module sh4alu_exec (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_empty,
   input  wire sh4alu_pkg::dec_item_type q_item,
   output logic                          q_pop,
   input  wire logic                     out_full,
   output logic                          out_push,
   output sh4alu_pkg::rsp_item_type      out_item
);

   // register file with per-entry valid bits (unwritten entries read zero)
   logic [31:0] regs_ff [16];
   logic [15:0] reg_vld_ff;

   sh4alu_pkg::dec_item_type e_item_ff;
   logic        e_valid_ff;
   logic [31:0] rn_ff, rb_ff;
   logic        t_ff, q_ff, m_ff, s_ff;
   logic [63:0] mac_ff;

   logic        advance, e_fire;
   logic        wr_en;
   logic [3:0]  wr_idx;
   logic [31:0] wr_data;

   // execute results
   logic        w, unk;
   logic [31:0] v;
   logic        t_in, q_in, m_in, s_in;
   logic [63:0] mac_in;

   // arithmetic
   logic [32:0]        add_c, sub_c, negc_c, div_c;
   logic [31:0]        sum, dif, div_tmp, xr;
   logic [5:0]         shr_k;
   logic               div_q;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;

   // stage handshake
   assign e_fire   = e_valid_ff && !out_full;
   assign advance  = !e_valid_ff || e_fire;
   assign q_pop    = advance && !q_empty;
   assign out_push = e_fire;

   assign wr_en   = e_fire && w;
   assign wr_idx  = e_item_ff.rn_idx;
   assign wr_data = v;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff <= !q_empty;
      end
   end

   // read stage with forwarding of the write in the same cycle
   always_ff @(posedge clock) begin
      if (q_pop) begin
         e_item_ff <= q_item;
         if (wr_en && wr_idx == q_item.rn_idx) begin
            rn_ff <= wr_data;
         end else begin
            rn_ff <= reg_vld_ff[q_item.rn_idx] ? regs_ff[q_item.rn_idx] : '0;
         end
         if (wr_en && wr_idx == q_item.rb_idx) begin
            rb_ff <= wr_data;
         end else begin
            rb_ff <= reg_vld_ff[q_item.rb_idx] ? regs_ff[q_item.rb_idx] : '0;
         end
      end
   end

   // register file write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         regs_ff[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_vld_ff <= '0;
      end else if (wr_en) begin
         reg_vld_ff[wr_idx] <= 1'b1;
      end
   end

   // shared datapath pieces
   assign sum    = rn_ff + rb_ff;
   assign dif    = rn_ff - rb_ff;
   assign xr     = rn_ff ^ rb_ff;
   assign add_c  = {1'b0, rn_ff} + {1'b0, rb_ff} + {32'd0, t_ff};
   assign sub_c  = {1'b0, rn_ff} - {1'b0, rb_ff} - {32'd0, t_ff};
   assign negc_c = 33'd0 - {1'b0, rb_ff} - {32'd0, t_ff};
   assign shr_k  = {1'b0, ~rb_ff[4:0]} + 6'd1;

   // one division step: subtract when Q equals M, else add
   assign div_tmp = {rn_ff[30:0], t_ff};
   assign div_c   = (q_ff == m_ff) ? ({1'b0, div_tmp} - {1'b0, rb_ff})
                                   : ({1'b0, div_tmp} + {1'b0, rb_ff});
   assign div_q   = rn_ff[31] ^ div_c[32] ^ m_ff;

   // shared multiplier operands
   always_comb begin
      mul_a = $signed({1'b0, rn_ff});
      mul_b = $signed({1'b0, rb_ff});
      case (e_item_ff.op)
         sh4alu_pkg::OP_MULUW: begin
            mul_a = $signed({17'd0, rn_ff[15:0]});
            mul_b = $signed({17'd0, rb_ff[15:0]});
         end
         sh4alu_pkg::OP_MULSW: begin
            mul_a = $signed({{17{rn_ff[15]}}, rn_ff[15:0]});
            mul_b = $signed({{17{rb_ff[15]}}, rb_ff[15:0]});
         end
         sh4alu_pkg::OP_DMULS: begin
            mul_a = $signed({rn_ff[31], rn_ff});
            mul_b = $signed({rb_ff[31], rb_ff});
         end
         default: ;
      endcase
   end

   assign prod = mul_a * mul_b;

   // operation execute
   always_comb begin
      w      = 1'b0;
      unk    = 1'b0;
      v      = '0;
      t_in   = t_ff;
      q_in   = q_ff;
      m_in   = m_ff;
      s_in   = s_ff;
      mac_in = mac_ff;
      unique case (e_item_ff.op)
         sh4alu_pkg::OP_CLRT:  t_in = 1'b0;
         sh4alu_pkg::OP_SETT:  t_in = 1'b1;
         sh4alu_pkg::OP_CLRS:  s_in = 1'b0;
         sh4alu_pkg::OP_SETS:  s_in = 1'b1;
         sh4alu_pkg::OP_DIV0U: begin
            q_in = 1'b0;
            m_in = 1'b0;
            t_in = 1'b0;
         end
         sh4alu_pkg::OP_MOVT: begin
            w = 1'b1;
            v = {31'd0, t_ff};
         end
         sh4alu_pkg::OP_MULL, sh4alu_pkg::OP_MULUW, sh4alu_pkg::OP_MULSW:
            mac_in = {mac_ff[63:32], prod[31:0]};
         sh4alu_pkg::OP_DMULU, sh4alu_pkg::OP_DMULS:
            mac_in = prod[63:0];
         sh4alu_pkg::OP_DIV0S: begin
            q_in = rn_ff[31];
            m_in = rb_ff[31];
            t_in = rn_ff[31] ^ rb_ff[31];
         end
         sh4alu_pkg::OP_TST:    t_in = ((rn_ff & rb_ff) == '0);
         sh4alu_pkg::OP_CMPSTR: t_in = (xr[31:24] == '0) || (xr[23:16] == '0) ||
                                       (xr[15:8] == '0) || (xr[7:0] == '0);
         sh4alu_pkg::OP_XTRCT: begin
            w = 1'b1;
            v = {rb_ff[15:0], rn_ff[31:16]};
         end
         sh4alu_pkg::OP_CMPEQ: t_in = (rn_ff == rb_ff);
         sh4alu_pkg::OP_CMPHS: t_in = (rn_ff >= rb_ff);
         sh4alu_pkg::OP_CMPGE: t_in = ($signed(rn_ff) >= $signed(rb_ff));
         sh4alu_pkg::OP_CMPHI: t_in = (rn_ff > rb_ff);
         sh4alu_pkg::OP_CMPGT: t_in = ($signed(rn_ff) > $signed(rb_ff));
         sh4alu_pkg::OP_DIV1: begin
            w    = 1'b1;
            v    = div_c[31:0];
            q_in = div_q;
            t_in = (div_q == m_ff);
         end
         sh4alu_pkg::OP_SUBC: begin
            w    = 1'b1;
            v    = sub_c[31:0];
            t_in = sub_c[32];
         end
         sh4alu_pkg::OP_SUBV: begin
            w    = 1'b1;
            v    = dif;
            t_in = xr[31] & (rn_ff[31] ^ dif[31]);
         end
         sh4alu_pkg::OP_ADDC: begin
            w    = 1'b1;
            v    = add_c[31:0];
            t_in = add_c[32];
         end
         sh4alu_pkg::OP_ADDV: begin
            w    = 1'b1;
            v    = sum;
            t_in = (rn_ff[31] ^ sum[31]) & (rb_ff[31] ^ sum[31]);
         end
         sh4alu_pkg::OP_SHLL: begin
            w    = 1'b1;
            v    = {rn_ff[30:0], 1'b0};
            t_in = rn_ff[31];
         end
         sh4alu_pkg::OP_SHLR: begin
            w    = 1'b1;
            v    = {1'b0, rn_ff[31:1]};
            t_in = rn_ff[0];
         end
         sh4alu_pkg::OP_ROTL: begin
            w    = 1'b1;
            v    = {rn_ff[30:0], rn_ff[31]};
            t_in = rn_ff[31];
         end
         sh4alu_pkg::OP_ROTR: begin
            w    = 1'b1;
            v    = {rn_ff[0], rn_ff[31:1]};
            t_in = rn_ff[0];
         end
         sh4alu_pkg::OP_DT: begin
            w    = 1'b1;
            v    = rn_ff - 32'd1;
            t_in = (rn_ff == 32'd1);
         end
         sh4alu_pkg::OP_CMPPZ: t_in = !rn_ff[31];
         sh4alu_pkg::OP_CMPPL: t_in = !rn_ff[31] && (rn_ff != '0);
         sh4alu_pkg::OP_SHAR: begin
            w    = 1'b1;
            v    = {rn_ff[31], rn_ff[31:1]};
            t_in = rn_ff[0];
         end
         sh4alu_pkg::OP_ROTCL: begin
            w    = 1'b1;
            v    = {rn_ff[30:0], t_ff};
            t_in = rn_ff[31];
         end
         sh4alu_pkg::OP_ROTCR: begin
            w    = 1'b1;
            v    = {t_ff, rn_ff[31:1]};
            t_in = rn_ff[0];
         end
         sh4alu_pkg::OP_SHAD: begin
            w = 1'b1;
            // negative count: right shift by 1..32 with sign fill
            v = rb_ff[31] ? 32'($signed(rn_ff) >>> shr_k) : (rn_ff << rb_ff[4:0]);
         end
         sh4alu_pkg::OP_SHLD: begin
            w = 1'b1;
            v = rb_ff[31] ? (rn_ff >> shr_k) : (rn_ff << rb_ff[4:0]);
         end
         sh4alu_pkg::OP_NOT: begin
            w = 1'b1;
            v = ~rb_ff;
         end
         sh4alu_pkg::OP_SWAPB: begin
            w = 1'b1;
            v = {rb_ff[31:16], rb_ff[7:0], rb_ff[15:8]};
         end
         sh4alu_pkg::OP_SWAPW: begin
            w = 1'b1;
            v = {rb_ff[15:0], rb_ff[31:16]};
         end
         sh4alu_pkg::OP_NEGC: begin
            w    = 1'b1;
            v    = negc_c[31:0];
            t_in = negc_c[32];
         end
         sh4alu_pkg::OP_NEG: begin
            w = 1'b1;
            v = 32'd0 - rb_ff;
         end
         sh4alu_pkg::OP_EXTUB: begin
            w = 1'b1;
            v = {24'd0, rb_ff[7:0]};
         end
         sh4alu_pkg::OP_EXTUW: begin
            w = 1'b1;
            v = {16'd0, rb_ff[15:0]};
         end
         sh4alu_pkg::OP_EXTSB: begin
            w = 1'b1;
            v = {{24{rb_ff[7]}}, rb_ff[7:0]};
         end
         sh4alu_pkg::OP_EXTSW: begin
            w = 1'b1;
            v = {{16{rb_ff[15]}}, rb_ff[15:0]};
         end
         sh4alu_pkg::OP_CMPIM:
            t_in = (rb_ff == {{24{e_item_ff.imm[7]}}, e_item_ff.imm});
         sh4alu_pkg::OP_TSTIM:
            t_in = ((rb_ff[7:0] & e_item_ff.imm) == '0);
         sh4alu_pkg::OP_LDREG: begin
            w = 1'b1;
            v = e_item_ff.value;
         end
         sh4alu_pkg::OP_LDMACH: mac_in = {e_item_ff.value, mac_ff[31:0]};
         sh4alu_pkg::OP_LDMACL: mac_in = {mac_ff[63:32], e_item_ff.value};
         default: unk = 1'b1;
      endcase
   end

   // architectural status update
   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff   <= 1'b0;
         q_ff   <= 1'b0;
         m_ff   <= 1'b0;
         s_ff   <= 1'b0;
         mac_ff <= '0;
      end else if (e_fire) begin
         t_ff   <= t_in;
         q_ff   <= q_in;
         m_ff   <= m_in;
         s_ff   <= s_in;
         mac_ff <= mac_in;
      end
   end

   // result item
   always_comb begin
      out_item.reg_written  = w;
      out_item.reg_number   = w ? e_item_ff.rn_idx : 4'd0;
      out_item.reg_result   = w ? v : 32'd0;
      out_item.t_out        = t_in;
      out_item.q_out        = q_in;
      out_item.m_out        = m_in;
      out_item.s_out        = s_in;
      out_item.mac_high_out = mac_in[63:32];
      out_item.mac_low_out  = mac_in[31:0];
      out_item.unknown_op   = unk;
   end

endmodule

`default_nettype wire

// File: sv/sh4_integer_alu_execute.sv
// ----------------------------------------------------------------------------
// sh4_integer_alu_execute
// SH-4 integer execute unit: decode front end, decoupling queue, register
// read / execute back end and result queue.
// ----------------------------------------------------------------------------
// Usage:
//  Items enter as a queue push (req_push while req_full is low) and carry a
//  mode, an opcode word and load data. Mode 0 executes the opcode, modes 1 to
//  3 load a general register, MACH or MACL. Each item yields one result,
//  which waits on the rsp_ ports while rsp_empty is low and leaves on
//  rsp_pop.
//  Path: an item passes from the decode queue into the register read stage,
//  then through the execute stage into the result queue.
//  Throughput: one item per cycle while the result queue has room; the
//  execute stage, with a combinational 32x32 multiplier and forwarding from
//  the write port, sets that figure, so dependent items also go back to back.
//  Reset clears both queues, the status bits, MAC and all registers to zero.
//  When the receiver stops popping, the result queue fills, the execute stage
//  holds, the decode queue fills and req_full rises; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sh4_integer_alu_execute #(
   parameter int unsigned QUEUE_DEPTH  = sh4alu_pkg::QUEUE_DEPTH,
   parameter int unsigned RESULT_DEPTH = sh4alu_pkg::RESULT_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_mode,
   input  wire logic [15:0] req_instruction,
   input  wire logic [3:0]  req_load_index,
   input  wire logic [31:0] req_load_value,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_reg_written,
   output logic [3:0]       rsp_reg_number,
   output logic [31:0]      rsp_reg_result,
   output logic             rsp_t_out,
   output logic             rsp_q_out,
   output logic             rsp_m_out,
   output logic             rsp_s_out,
   output logic [31:0]      rsp_mac_high_out,
   output logic [31:0]      rsp_mac_low_out,
   output logic             rsp_unknown_op
);

   localparam int unsigned DEC_W = $bits(sh4alu_pkg::dec_item_type);
   localparam int unsigned RSP_W = $bits(sh4alu_pkg::rsp_item_type);

   sh4alu_pkg::dec_item_type dec_item, q_item;
   sh4alu_pkg::rsp_item_type ex_item, rsp_item;
   logic [DEC_W-1:0]         q_data;
   logic [RSP_W-1:0]         rsp_data;
   logic                     q_empty, q_pop;
   logic                     out_full, out_push;

   // front end
   sh4alu_decode u_decode (
      .mode        (req_mode),
      .instruction (req_instruction),
      .load_index  (req_load_index),
      .load_value  (req_load_value),
      .item        (dec_item)
   );

   // queue between front and back
   sh4alu_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (DEC_W)
   ) u_dec_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (dec_item),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   assign q_item = sh4alu_pkg::dec_item_type'(q_data);

   // back end
   sh4alu_exec u_exec (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_item (ex_item)
   );

   // result queue
   sh4alu_fifo #(
      .DEPTH (RESULT_DEPTH),
      .WIDTH (RSP_W)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (ex_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   assign rsp_item         = sh4alu_pkg::rsp_item_type'(rsp_data);
   assign rsp_reg_written  = rsp_item.reg_written;
   assign rsp_reg_number   = rsp_item.reg_number;
   assign rsp_reg_result   = rsp_item.reg_result;
   assign rsp_t_out        = rsp_item.t_out;
   assign rsp_q_out        = rsp_item.q_out;
   assign rsp_m_out        = rsp_item.m_out;
   assign rsp_s_out        = rsp_item.s_out;
   assign rsp_mac_high_out = rsp_item.mac_high_out;
   assign rsp_mac_low_out  = rsp_item.mac_low_out;
   assign rsp_unknown_op   = rsp_item.unknown_op;

endmodule

`default_nettype wire

// File: sv/sh4alu_checker.sv
// ----------------------------------------------------------------------------
// sh4alu_checker
// Port-level assertions for the SH-4 integer execute unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sh4alu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_push,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic        rsp_reg_written,
   input wire logic [3:0]  rsp_reg_number,
   input wire logic [31:0] rsp_reg_result,
   input wire logic        rsp_unknown_op
);

   // nothing waits right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("result queue not empty after reset");

   // an unknown opcode never writes a register
   a_unknown_no_write: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_unknown_op) |-> !rsp_reg_written)
      else $error("unknown opcode wrote a register");

   // no write means zero number and result
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_reg_written) |-> (rsp_reg_number == 4'd0 &&
                                            rsp_reg_result == 32'd0))
      else $error("register fields set without a write");

   // a waiting item holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_reg_result) &&
                                    $stable(rsp_reg_number)))
      else $error("waiting item changed");

   // a refused push only happens while results wait
   a_full_needs_work: assert property (@(posedge clock) disable iff (reset)
      (req_push && req_full) |-> !rsp_empty)
      else $error("input refused with no result waiting");

endmodule

bind sh4_integer_alu_execute sh4alu_checker u_sh4alu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_push        (req_push),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_reg_written (rsp_reg_written),
   .rsp_reg_number  (rsp_reg_number),
   .rsp_reg_result  (rsp_reg_result),
   .rsp_unknown_op  (rsp_unknown_op)
);

`default_nettype wire
